[rtl/core/tbk_pkg.sv]
// shared types and codes for the timer bank
`default_nettype none
package tbk_pkg;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_START   = 3'd1,
      OP_DELAY   = 3'd2,
      OP_PAUSE   = 3'd3,
      OP_RESUME  = 3'd4,
      OP_RESTART = 3'd5,
      OP_CANCEL  = 3'd6,
      OP_READ    = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_ID      = 2'd1,
      ST_ZERO_PERIOD = 2'd2,
      ST_BAD_STATE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CH_PASSIVE = 2'd0,
      CH_ACTIVE  = 2'd1,
      CH_PAUSED  = 2'd2
   } chan_state_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_EXEC  = 2'd1,
      FSM_FLUSH = 2'd2
   } fsm_type;

   localparam logic KIND_RESPONSE = 1'b0;
   localparam logic KIND_EVENT    = 1'b1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  timer_id;
      logic        periodic;
      logic [31:0] time_value;
      logic        notify;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [7:0]  channel;
      logic [1:0]  chan_state;
      logic        chan_periodic;
      logic [31:0] reload_value;
      logic [31:0] remaining_ticks;
      logic        last;
   } rsp_type;

   // control from sequencer to output queue
   typedef struct packed {
      logic push;
      logic flush;
   } q_ctrl_type;

   // status from output queue to sequencer
   typedef struct packed {
      logic push_ready;
      logic flush_done;
   } q_stat_type;

endpackage
`default_nettype wire

[rtl/core/tbk_store.sv]
// channel state memory with per-entry valid bits and registered read
`default_nettype none
module tbk_store
   import tbk_pkg::*;
#(
   parameter int  TIMERS    = 16,
   parameter int  TIME_BITS = 32,
   localparam int IDX_W     = (TIMERS > 1) ? $clog2(TIMERS) : 1,
   localparam int ENTRY_W   = 4 + 2 * TIME_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [IDX_W-1:0]             rd_addr,
   output logic      [ENTRY_W-1:0]           rd_entry,
   input  wire logic                         wr_en,
   input  wire logic [IDX_W-1:0]             wr_addr,
   input  wire logic [ENTRY_W-1:0]           wr_entry
);
   logic [ENTRY_W-1:0] entry_mem_ff [TIMERS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_valid_ff;
   logic [TIMERS-1:0]  valid_ff;
   logic [TIMERS-1:0]  valid_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff  <= entry_mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // an entry never written reads as the reset value
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

[rtl/core/tbk_alu.sv]
// read-modify-write update of one channel for a tick or command
`default_nettype none
module tbk_alu
   import tbk_pkg::*;
#(
   parameter int  TIME_BITS = 32,
   localparam int ENTRY_W   = 4 + 2 * TIME_BITS
) (
   input  wire logic [2:0]               opcode,
   input  wire logic                     bad_id,
   input  wire logic [7:0]               channel,
   input  wire logic                     periodic,
   input  wire logic [31:0]              time_value,
   input  wire logic                     notify,
   input  wire logic [ENTRY_W-1:0]       entry_in,
   output logic      [ENTRY_W-1:0]       entry_out,
   output logic                          wr_en,
   output logic                          emit,
   output rsp_type                       result
);
   logic [1:0]           st;
   logic                 per_s;
   logic                 ntf_s;
   logic [TIME_BITS-1:0] rel;
   logic [TIME_BITS-1:0] rem;
   logic [TIME_BITS-1:0] tv;
   logic [TIME_BITS-1:0] rem_dec;
   logic [TIME_BITS:0]   sum;
   logic [1:0]           n_st;
   logic                 n_per;
   logic                 n_ntf;
   logic [TIME_BITS-1:0] n_rel;
   logic [TIME_BITS-1:0] n_rem;
   logic [1:0]           status;

   always_comb begin
      {st, per_s, ntf_s, rel, rem} = entry_in;
      tv      = TIME_BITS'(time_value);
      rem_dec = (rem == '0) ? '0 : rem - TIME_BITS'(1);
      sum     = {1'b0, rem} + {1'b0, tv};
      n_st    = st;
      n_per   = per_s;
      n_ntf   = ntf_s;
      n_rel   = rel;
      n_rem   = rem;
      wr_en   = 1'b0;
      emit    = 1'b1;
      status  = ST_OK;
      if (bad_id) begin
         status = ST_BAD_ID;
         n_st   = '0;
         n_per  = 1'b0;
         n_ntf  = 1'b0;
         n_rel  = '0;
         n_rem  = '0;
      end else begin
         case (opcode)
            OP_TICK: begin
               emit = 1'b0;
               if (st == CH_ACTIVE) begin
                  wr_en = 1'b1;
                  n_rem = rem_dec;
                  if (rem_dec == '0) begin
                     // expiry: periodic reloads, one-shot stops
                     if (per_s) begin
                        n_rem = rel;
                     end else begin
                        n_st = CH_PASSIVE;
                     end
                     emit = ntf_s;
                  end
               end
            end
            OP_START: begin
               if (periodic && (tv == '0)) begin
                  status = ST_ZERO_PERIOD;
               end else begin
                  wr_en = 1'b1;
                  n_rel = tv;
                  n_rem = tv;
                  n_per = periodic;
                  n_st  = CH_ACTIVE;
                  n_ntf = notify;
               end
            end
            OP_DELAY: begin
               if (st != CH_PASSIVE) begin
                  wr_en = 1'b1;
                  // saturate at the time maximum
                  n_rem = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
               end else begin
                  status = ST_BAD_STATE;
               end
            end
            OP_PAUSE: begin
               if (st == CH_ACTIVE) begin
                  wr_en = 1'b1;
                  n_st  = CH_PAUSED;
               end else begin
                  status = ST_BAD_STATE;
               end
            end
            OP_RESUME: begin
               if (st == CH_PAUSED) begin
                  wr_en = 1'b1;
                  n_st  = CH_ACTIVE;
               end else begin
                  status = ST_BAD_STATE;
               end
            end
            OP_RESTART: begin
               if (st != CH_PASSIVE) begin
                  wr_en = 1'b1;
                  n_rem = rel;
                  n_st  = CH_ACTIVE;
               end else begin
                  status = ST_BAD_STATE;
               end
            end
            OP_CANCEL: begin
               wr_en = 1'b1;
               n_st  = CH_PASSIVE;
               n_rem = '0;
               n_ntf = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign entry_out = {n_st, n_per, n_ntf, n_rel, n_rem};

   always_comb begin
      result.kind            = (opcode == OP_TICK) ? KIND_EVENT : KIND_RESPONSE;
      result.status          = status;
      result.channel         = channel;
      result.chan_state      = n_st;
      result.chan_periodic   = n_per;
      result.reload_value    = 32'(n_rel);
      result.remaining_ticks = 32'(n_rem);
      result.last            = 1'b0;
   end

endmodule
`default_nettype wire

[rtl/core/tbk_outq.sv]
// one pending slot plus output register, sets last on flush
`default_nettype none
module tbk_outq
   import tbk_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_ctrl_type q_ctrl,
   input  wire rsp_type    push_data,
   output q_stat_type      q_stat,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data
);
   logic    pend_valid_ff;
   logic    pend_valid_in;
   rsp_type pend_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_ff;
   rsp_type out_in;
   logic    out_free;
   logic    load_out;

   always_comb begin
      out_free          = !out_valid_ff || !rsp_stall;
      q_stat.push_ready = !pend_valid_ff || out_free;
      q_stat.flush_done = !pend_valid_ff || out_free;
      load_out          = pend_valid_ff && out_free && (q_ctrl.push || q_ctrl.flush);
      out_in            = pend_ff;
      out_in.last       = q_ctrl.flush;
      pend_valid_in     = pend_valid_ff;
      if (q_ctrl.push && q_stat.push_ready) begin
         pend_valid_in = 1'b1;
      end else if (q_ctrl.flush && out_free) begin
         pend_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_ctrl.push && q_stat.push_ready) begin
         pend_ff <= push_data;
      end
      if (load_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

[rtl/core/multi_channel_timer_bank_unit.sv]
// timer bank top level: sequencer over the channel memory
// a command response passes from the update unit through the pending slot to the output register
// a new command is accepted only once the sequencer is idle again; a tick sweeps every channel,
//   set by the single read port of the channel memory visiting one channel per cycle when not held
// output back-pressure stretches a tick while an event waits for the output
// reset: synchronous; clears the sequencer, the output queue and all memory valid bits,
//   so every channel reads passive with zero counts at once, with no clearing pass
`default_nettype none
module multi_channel_timer_bank_unit
   import tbk_pkg::*;
#(
   parameter int TIMERS    = 16,
   parameter int TIME_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int IDX_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int ENTRY_W = 4 + 2 * TIME_BITS;

   // sequencer state
   fsm_type          state_ff;
   fsm_type          state_in;
   req_type          req_ff;
   req_type          req_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;

   // memory port
   logic               st_rd_en;
   logic [IDX_W-1:0]   st_rd_addr;
   logic [ENTRY_W-1:0] st_rd_entry;
   logic               st_wr_en;
   logic [ENTRY_W-1:0] st_wr_entry;

   // update unit
   logic    alu_wr_en;
   logic    alu_emit;
   rsp_type alu_result;
   logic    bad_id;
   logic    is_tick;
   logic    last_chan;
   logic    proceed;
   logic    accept;
   logic [7:0] chan_id;

   q_ctrl_type q_ctrl;
   q_stat_type q_stat;

   assign is_tick   = (req_ff.opcode == OP_TICK);
   assign bad_id    = !is_tick && ({1'b0, req_ff.timer_id} >= 9'(TIMERS));
   assign last_chan = (idx_ff == IDX_W'(TIMERS - 1));
   assign chan_id   = is_tick ? 8'(idx_ff) : req_ff.timer_id;
   // an item without output always proceeds; one with output waits for queue room
   assign proceed   = !alu_emit || q_stat.push_ready;
   assign accept    = req_valid && !req_stall;

   tbk_store #(
      .TIMERS    (TIMERS),
      .TIME_BITS (TIME_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (st_rd_en),
      .rd_addr  (st_rd_addr),
      .rd_entry (st_rd_entry),
      .wr_en    (st_wr_en),
      .wr_addr  (idx_ff),
      .wr_entry (st_wr_entry)
   );

   tbk_alu #(
      .TIME_BITS (TIME_BITS)
   ) u_alu (
      .opcode     (req_ff.opcode),
      .bad_id     (bad_id),
      .channel    (chan_id),
      .periodic   (req_ff.periodic),
      .time_value (req_ff.time_value),
      .notify     (req_ff.notify),
      .entry_in   (st_rd_entry),
      .entry_out  (st_wr_entry),
      .wr_en      (alu_wr_en),
      .emit       (alu_emit),
      .result     (alu_result)
   );

   tbk_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .q_ctrl    (q_ctrl),
      .push_data (alu_result),
      .q_stat    (q_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            // commands touch one channel, a tick sweeps to the last one
            if (proceed && (!is_tick || last_chan)) begin
               state_in = FSM_FLUSH;
            end
         end
         FSM_FLUSH: begin
            if (q_stat.flush_done) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall    = 1'b1;
      req_in       = req_ff;
      idx_in       = idx_ff;
      st_rd_en     = 1'b0;
      st_rd_addr   = idx_ff;
      st_wr_en     = 1'b0;
      q_ctrl.push  = 1'b0;
      q_ctrl.flush = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            // the first read goes out with the accepting edge
            st_rd_addr = (req_data.opcode == OP_TICK) ? '0 : req_data.timer_id[IDX_W-1:0];
            st_rd_en   = req_valid;
            if (accept) begin
               req_in = req_data;
               idx_in = st_rd_addr;
            end
         end
         FSM_EXEC: begin
            st_wr_en    = alu_wr_en && proceed;
            q_ctrl.push = alu_emit && proceed;
            // during a tick, fetch the next channel while this one is written back
            if (proceed && is_tick && !last_chan) begin
               st_rd_en   = 1'b1;
               st_rd_addr = idx_ff + IDX_W'(1);
               idx_in     = st_rd_addr;
            end
         end
         FSM_FLUSH: begin
            // the held transaction leaves with last set
            q_ctrl.flush = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
   end

`ifndef SYNTH
   // memory is written back only from the execute step
   assert property (@(posedge clock) disable iff (reset)
      st_wr_en |-> (state_ff == FSM_EXEC))
      else $error("channel write outside execute");

   // the sweep index never passes the last channel
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_EXEC) |-> (idx_ff <= IDX_W'(TIMERS - 1)))
      else $error("channel index out of range");

   // command responses are always single and last
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_RESPONSE)) |-> rsp_data.last)
      else $error("response without last");

   // expiry events always report success
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_EVENT)) |-> (rsp_data.status == ST_OK))
      else $error("event with error status");
`endif

endmodule
`default_nettype wire

[verif/tb_multi_channel_timer_bank_unit.sv]
`timescale 1ns / 1ps
// self-checking testbench for the timer bank: directed and random transactions
module tb_multi_channel_timer_bank_unit;
   import tbk_pkg::*;

   localparam int TIMERS        = 16;
   localparam int TIME_BITS     = 32;
   // worst case is far below this: every tick flushing all channels under heavy stall
   localparam int CYCLE_LIMIT   = 400000;
   // a tick with no notified channel still occupies the sequencer while it sweeps every channel
   localparam int SETTLE_CYCLES = TIMERS + 8;
   localparam int HOLD_CYCLES   = 400;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // idling controls, changed between phases
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int mismatches    = 0;
   int cycles        = 0;

   // channel model state, mirrors what the bank holds after each accepted transaction
   logic [31:0]    reload_q   [TIMERS];
   logic [31:0]    count_q    [TIMERS];
   chan_state_type state_q    [TIMERS];
   logic           periodic_q [TIMERS];
   logic           notify_q   [TIMERS];

   // responses and expiry events still owed by the bank, oldest first
   rsp_type bank_outputs_due [$];

   multi_channel_timer_bank_unit #(
      .TIMERS    (TIMERS),
      .TIME_BITS (TIME_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop in case the bank hangs or drops a transaction
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver side: a long hold-off when requested, otherwise random stall
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // snapshot of one channel as the bank reports it
   function automatic rsp_type channel_report(logic kind, status_type st, int ch, logic last);
      rsp_type r;
      r.kind            = kind;
      r.status          = st;
      r.channel         = 8'(ch);
      r.chan_state      = state_q[ch];
      r.chan_periodic   = periodic_q[ch];
      r.reload_value    = reload_q[ch];
      r.remaining_ticks = count_q[ch];
      r.last            = last;
      return r;
   endfunction

   // apply one accepted transaction to the channel model and queue what it produces
   function automatic void advance_bank(input req_type r);
      rsp_type     held;
      rsp_type     resp;
      bit          have_held;
      int          ch;
      status_type  st;
      logic [32:0] sum;
      have_held = 1'b0;
      held      = '0;
      st        = ST_OK;
      ch        = r.timer_id;
      if (r.opcode == OP_TICK) begin
         // count down every active channel, events come out in ascending channel order
         for (int i = 0; i < TIMERS; i++) begin
            if (state_q[i] == CH_ACTIVE) begin
               // a channel already at zero expires without counting
               if (count_q[i] != 0)
                  count_q[i] = count_q[i] - 1;
               if (count_q[i] == 0) begin
                  if (periodic_q[i])
                     count_q[i] = reload_q[i];
                  else
                     state_q[i] = CH_PASSIVE;
                  if (notify_q[i]) begin
                     if (have_held)
                        bank_outputs_due.push_back(held);
                     held      = channel_report(KIND_EVENT, ST_OK, i, 1'b0);
                     have_held = 1'b1;
                  end
               end
            end
         end
         // final event of the tick carries last, a silent tick gives nothing
         if (have_held) begin
            held.last = 1'b1;
            bank_outputs_due.push_back(held);
         end
      end else if (r.timer_id >= TIMERS) begin
         // out-of-range id: only the id comes back, no state touched
         resp         = '0;
         resp.kind    = KIND_RESPONSE;
         resp.status  = ST_BAD_ID;
         resp.channel = r.timer_id;
         resp.last    = 1'b1;
         bank_outputs_due.push_back(resp);
      end else begin
         case (r.opcode)
            OP_START: begin
               if (r.periodic && r.time_value == 0) begin
                  st = ST_ZERO_PERIOD;
               end else begin
                  reload_q[ch]   = r.time_value;
                  count_q[ch]    = r.time_value;
                  periodic_q[ch] = r.periodic;
                  state_q[ch]    = CH_ACTIVE;
                  notify_q[ch]   = r.notify;
               end
            end
            OP_DELAY: begin
               if (state_q[ch] != CH_PASSIVE) begin
                  // saturate at the largest count
                  sum         = {1'b0, count_q[ch]} + {1'b0, r.time_value};
                  count_q[ch] = sum[32] ? '1 : sum[31:0];
               end else begin
                  st = ST_BAD_STATE;
               end
            end
            OP_PAUSE: begin
               if (state_q[ch] == CH_ACTIVE)
                  state_q[ch] = CH_PAUSED;
               else
                  st = ST_BAD_STATE;
            end
            OP_RESUME: begin
               if (state_q[ch] == CH_PAUSED)
                  state_q[ch] = CH_ACTIVE;
               else
                  st = ST_BAD_STATE;
            end
            OP_RESTART: begin
               if (state_q[ch] != CH_PASSIVE) begin
                  count_q[ch] = reload_q[ch];
                  state_q[ch] = CH_ACTIVE;
               end else begin
                  st = ST_BAD_STATE;
               end
            end
            OP_CANCEL: begin
               // reload value and type survive a cancel
               state_q[ch]  = CH_PASSIVE;
               count_q[ch]  = '0;
               notify_q[ch] = 1'b0;
            end
            default: begin
            end
         endcase
         bank_outputs_due.push_back(channel_report(KIND_RESPONSE, st, ch, 1'b1));
      end
   endfunction

   task automatic log_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t %s: expected kind=%0d status=%0d ch=%0d state=%0d per=%0d",
                   " reload=%h left=%h last=%0d"},
                  $realtime, what, want.kind, want.status, want.channel, want.chan_state,
                  want.chan_periodic, want.reload_value, want.remaining_ticks, want.last);
      if (mismatches <= 10)
         $display({"%0t %s: actual   kind=%0d status=%0d ch=%0d state=%0d per=%0d",
                   " reload=%h left=%h last=%0d"},
                  $realtime, what, got.kind, got.status, got.channel, got.chan_state,
                  got.chan_periodic, got.reload_value, got.remaining_ticks, got.last);
   endtask

   // every accepted output transaction is matched against the oldest owed one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (bank_outputs_due.size() == 0) begin
            log_mismatch("unexpected output", '0, rsp_data);
         end else begin
            want = bank_outputs_due.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.status !== want.status ||
                rsp_data.channel !== want.channel || rsp_data.chan_state !== want.chan_state ||
                rsp_data.chan_periodic !== want.chan_periodic ||
                rsp_data.reload_value !== want.reload_value ||
                rsp_data.remaining_ticks !== want.remaining_ticks ||
                rsp_data.last !== want.last)
               log_mismatch("field mismatch", want, rsp_data);
         end
      end
   end

   function automatic req_type cmd(opcode_type op, int id, bit per, logic [31:0] tv, bit ntf);
      req_type r;
      r.opcode     = op;
      r.timer_id   = 8'(id);
      r.periodic   = per;
      r.time_value = tv;
      r.notify     = ntf;
      return r;
   endfunction

   // one input transaction; valid stays high when the next one follows without a gap
   task automatic send_item(input req_type item);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_bank(item);
   endtask

   // stop offering and wait until everything owed has come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (bank_outputs_due.size() != 0);
   endtask

   // mostly legal traffic on valid channels, the rest is any field value at all
   function automatic req_type random_command();
      req_type r;
      int      pick;
      if ($urandom_range(99) < 25) begin
         r.opcode     = 3'($urandom_range(7));
         r.timer_id   = 8'($urandom_range(255));
         r.periodic   = 1'($urandom_range(1));
         r.time_value = $urandom;
         r.notify     = 1'($urandom_range(1));
      end else begin
         pick         = $urandom_range(99);
         r.timer_id   = 8'($urandom_range(TIMERS - 1));
         r.periodic   = 1'($urandom_range(1));
         r.notify     = ($urandom_range(3) != 0);
         r.time_value = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(6));
         if (pick < 35)
            r.opcode = OP_TICK;
         else if (pick < 55)
            r.opcode = OP_START;
         else if (pick < 62)
            r.opcode = OP_DELAY;
         else if (pick < 70)
            r.opcode = OP_PAUSE;
         else if (pick < 78)
            r.opcode = OP_RESUME;
         else if (pick < 85)
            r.opcode = OP_RESTART;
         else if (pick < 92)
            r.opcode = OP_CANCEL;
         else
            r.opcode = OP_READ;
      end
      return r;
   endfunction

   // every operation, field extremes and the corner cases of each command
   task automatic test_directed();
      send_item(cmd(OP_READ, 0, 1'b0, 32'h0, 1'b0));               // channel after reset
      send_item(cmd(OP_READ, 255, 1'b1, 32'hFFFF_FFFF, 1'b1));     // highest id, bad
      send_item(cmd(OP_START, TIMERS, 1'b1, 32'hFFFF_FFFF, 1'b1)); // first bad id
      send_item(cmd(OP_START, 0, 1'b1, 32'h0, 1'b1));              // periodic with zero timeout
      send_item(cmd(OP_START, 0, 1'b0, 32'h0, 1'b1));              // one-shot at zero
      send_item(cmd(OP_START, TIMERS - 1, 1'b1, 32'd2, 1'b1));
      send_item(cmd(OP_START, 1, 1'b1, 32'hFFFF_FFF0, 1'b0));
      send_item(cmd(OP_DELAY, 1, 1'b0, 32'hFFFF_FFFF, 1'b0));      // saturates
      send_item(cmd(OP_DELAY, 2, 1'b0, 32'd5, 1'b0));              // passive, bad state
      send_item(cmd(OP_PAUSE, 1, 1'b0, 32'h0, 1'b0));
      send_item(cmd(OP_PAUSE, 1, 1'b0, 32'h0, 1'b0));              // already paused
      send_item(cmd(OP_TICK, 0, 1'b0, 32'h0, 1'b0));               // zero one-shot fires
      send_item(cmd(OP_TICK, 0, 1'b0, 32'h0, 1'b0));               // periodic reloads
      send_item(cmd(OP_RESUME, 1, 1'b0, 32'h0, 1'b0));
      send_item(cmd(OP_RESUME, 1, 1'b0, 32'h0, 1'b0));             // not paused
      send_item(cmd(OP_RESTART, 1, 1'b0, 32'h0, 1'b0));
      send_item(cmd(OP_RESTART, 3, 1'b0, 32'h0, 1'b0));            // passive, bad state
      send_item(cmd(OP_CANCEL, TIMERS - 1, 1'b0, 32'h0, 1'b0));
      send_item(cmd(OP_CANCEL, 4, 1'b0, 32'h0, 1'b0));             // cancel of a passive channel
      send_item(cmd(OP_START, 2, 1'b0, 32'd1, 1'b0));
      send_item(cmd(OP_TICK, 0, 1'b0, 32'h0, 1'b0));               // expiry with no event
      send_item(cmd(OP_READ, 2, 1'b0, 32'h0, 1'b0));
      send_item(cmd(OP_DELAY, 1, 1'b0, 32'h0, 1'b0));
      send_item(cmd(OP_READ, TIMERS, 1'b0, 32'h0, 1'b0));
      send_item(cmd(OP_TICK, 255, 1'b1, 32'hFFFF_FFFF, 1'b1));     // nothing notified
      drain();
   endtask

   // arm every channel close to expiry so that ticks flush many events at once
   task automatic test_tick_burst();
      for (int ch = 0; ch < TIMERS; ch++)
         send_item(cmd(OP_START, ch, 1'($urandom_range(1)), 32'($urandom_range(2)),
                       $urandom_range(7) != 0));
      repeat (4) send_item(cmd(OP_TICK, 0, 1'b0, 32'h0, 1'b0));
      drain();
   endtask

   task automatic test_random_phase(input int count);
      repeat (count) send_item(random_command());
      drain();
   endtask

   // receiver holds off while transactions keep coming, so the bank backs up
   task automatic test_backpressure();
      hold_left = HOLD_CYCLES;
      repeat (40) send_item(random_command());
      drain();
   endtask

   initial begin
      for (int i = 0; i < TIMERS; i++) begin
         reload_q[i]   = '0;
         count_q[i]    = '0;
         state_q[i]    = CH_PASSIVE;
         periodic_q[i] = 1'b0;
         notify_q[i]   = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // no idling on either side
      test_directed();
      test_tick_burst();
      test_random_phase(75);

      // sender idle most of the time
      send_idle_pct = 58;
      stall_pct     = 0;
      test_random_phase(75);

      // receiver stalling most of the time
      send_idle_pct = 0;
      stall_pct     = 58;
      test_tick_burst();
      test_random_phase(75);

      // both sides idle now and then
      send_idle_pct = 27;
      stall_pct     = 27;
      test_tick_burst();
      test_random_phase(75);
      test_backpressure();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && bank_outputs_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
